// ----- hdl/wsrs_pkg.sv -----
package wsrs_pkg;

	// Maximum number of covariate columns carried by one row.
	localparam int unsigned MAX_COLS = 8;

	// Fixed field widths.
	localparam int unsigned VAL_W  = 16;   // Q4.12 covariates, coefficients, outcome
	localparam int unsigned WGT_W  = 16;   // Q8.8 row weight
	localparam int unsigned IDX_W  = 4;    // configuration register index
	localparam int unsigned PROD_W = 2 * VAL_W;   // Q8.24 lane product
	localparam int unsigned R24_W  = 38;   // residual in Q.24, room for eight products
	localparam int unsigned FRAC_DROP = 12;       // Q.24 to Q.12
	localparam int unsigned RFULL_W = R24_W - FRAC_DROP;
	localparam int unsigned RES_W  = 24;   // saturated Q12.12 residual
	localparam int unsigned SQ_W   = 2 * RES_W - 1;   // residual squared, never negative
	localparam int unsigned TERM_W = SQ_W + WGT_W - 1; // weighted square, halved
	localparam int unsigned ACC_W  = 63;   // accumulator magnitude, 0 .. 2^63-1
	localparam int unsigned LOSS_W = 64;

	localparam logic signed [RFULL_W-1:0] RES_MAX = RFULL_W'((1 << (RES_W - 1)) - 1);
	localparam logic signed [RFULL_W-1:0] RES_MIN = -RFULL_W'(1 << (RES_W - 1));
	localparam logic signed [R24_W-1:0]   RND_HALF = R24_W'(1 << (FRAC_DROP - 1));

	// Per-row sideband that travels alongside the arithmetic.
	typedef struct packed {
		logic             valid;
		logic             last;
		logic             sat;
		logic [WGT_W-1:0] weight;
	} tag_t;

endpackage

// ----- hdl/weighted_squared_residual_sum.sv -----
// Weighted least-squares loss over a stream of data rows. Each row beat carries
// up to eight Q4.12 covariates, a Q4.12 outcome and a Q8.8 weight; the block
// accepts one row per clock, and a row marked last_row produces one result
// beat: the negated half weighted sum of squared residuals in Q31.32, plus a
// flag that is set if the residual or the accumulator saturated anywhere in
// that data set. The single 64-bit accumulator add in the final stage is the
// only dependence between rows. The whole pipeline holds while a result beat
// waits on a stalled output, so in_stall follows out_stall in that case. The
// user must write coefficients through the configuration port only while no
// row is in flight; the block does not enforce it. Writes to an index at or
// above NUM_COLS are dropped and those columns act as a zero coefficient.
module weighted_squared_residual_sum #(
	parameter int unsigned NUM_COLS = wsrs_pkg::MAX_COLS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [wsrs_pkg::IDX_W-1:0]           cfg_index,
	input  logic [wsrs_pkg::VAL_W-1:0]           cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [wsrs_pkg::VAL_W-1:0]    cov_0,
	input  logic signed [wsrs_pkg::VAL_W-1:0]    cov_1,
	input  logic signed [wsrs_pkg::VAL_W-1:0]    cov_2,
	input  logic signed [wsrs_pkg::VAL_W-1:0]    cov_3,
	input  logic signed [wsrs_pkg::VAL_W-1:0]    cov_4,
	input  logic signed [wsrs_pkg::VAL_W-1:0]    cov_5,
	input  logic signed [wsrs_pkg::VAL_W-1:0]    cov_6,
	input  logic signed [wsrs_pkg::VAL_W-1:0]    cov_7,
	input  logic signed [wsrs_pkg::VAL_W-1:0]    outcome,
	input  logic [wsrs_pkg::WGT_W-1:0]           row_weight,
	input  logic                                 last_row,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [wsrs_pkg::LOSS_W-1:0]   neg_loss,
	output logic                                 saturated
);

	logic signed [wsrs_pkg::VAL_W-1:0]  cov_a [wsrs_pkg::MAX_COLS];
	logic signed [wsrs_pkg::VAL_W-1:0]  coef_q [NUM_COLS];
	logic signed [wsrs_pkg::PROD_W-1:0] prod_s1 [NUM_COLS];
	logic signed [wsrs_pkg::VAL_W-1:0]  outcome_s1;
	wsrs_pkg::tag_t                     tag_in;
	wsrs_pkg::tag_t                     tag_s1;
	logic signed [wsrs_pkg::RES_W-1:0]  res_s3;
	wsrs_pkg::tag_t                     tag_s3;
	logic                               advance;

	assign cov_a[0] = cov_0;
	assign cov_a[1] = cov_1;
	assign cov_a[2] = cov_2;
	assign cov_a[3] = cov_3;
	assign cov_a[4] = cov_4;
	assign cov_a[5] = cov_5;
	assign cov_a[6] = cov_6;
	assign cov_a[7] = cov_7;

	// The pipeline moves unless a finished result beat is being held.
	assign advance   = !out_valid || !out_stall;
	assign in_stall  = !advance;
	assign cfg_ready = 1'b1;

	// Coefficient registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NUM_COLS; j++) begin
				coef_q[j] <= '0;
			end
		end else if (cfg_valid) begin
			for (int j = 0; j < NUM_COLS; j++) begin
				if (cfg_index == wsrs_pkg::IDX_W'(j)) begin
					coef_q[j] <= cfg_data;
				end
			end
		end
	end

	// Input stage sideband.
	always_comb begin
		tag_in        = '0;
		tag_in.valid  = in_valid;
		tag_in.last   = last_row;
		tag_in.weight = row_weight;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			outcome_s1 <= outcome;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (advance) begin
			tag_s1 <= tag_in;
		end
	end

	// One multiplier lane per active column.
	for (genvar j = 0; j < NUM_COLS; j++) begin : g_lane
		wsrs_lane u_lane (
			.clk     (clk),
			.advance (advance),
			.cov     (cov_a[j]),
			.coef    (coef_q[j]),
			.prod_s1 (prod_s1[j])
		);
	end

	wsrs_merge #(
		.NUM_COLS (NUM_COLS)
	) u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.prod_s1    (prod_s1),
		.outcome_s1 (outcome_s1),
		.tag_s1     (tag_s1),
		.res_s3     (res_s3),
		.tag_s3     (tag_s3)
	);

	wsrs_loss u_loss (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.res_s3    (res_s3),
		.tag_s3    (tag_s3),
		.out_valid (out_valid),
		.neg_loss  (neg_loss),
		.saturated (saturated)
	);

	// An accepted row enters the first stage.
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> tag_s1.valid)
		else $error("accepted row did not enter the pipeline");

	// A held pipeline keeps its residual stage intact.
	a_hold_s3: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(tag_s3) && $stable(res_s3))
		else $error("residual stage changed while stalled");

	// A new result beat appears only when the pipeline has just advanced.
	a_result_moves: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(advance))
		else $error("result beat appeared while pipeline was held");

endmodule

// ----- hdl/wsrs_lane.sv -----
module wsrs_lane (
	input  logic                                 clk,
	input  logic                                 advance,
	input  logic signed [wsrs_pkg::VAL_W-1:0]    cov,
	input  logic signed [wsrs_pkg::VAL_W-1:0]    coef,
	output logic signed [wsrs_pkg::PROD_W-1:0]   prod_s1
);

	// One column: exact Q8.24 product of covariate and coefficient.
	always_ff @(posedge clk) begin
		if (advance) begin
			prod_s1 <= cov * coef;
		end
	end

endmodule

// ----- hdl/wsrs_merge.sv -----
module wsrs_merge #(
	parameter int unsigned NUM_COLS = wsrs_pkg::MAX_COLS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  advance,
	input  logic signed [wsrs_pkg::PROD_W-1:0]    prod_s1 [NUM_COLS],
	input  logic signed [wsrs_pkg::VAL_W-1:0]     outcome_s1,
	input  wsrs_pkg::tag_t                        tag_s1,
	output logic signed [wsrs_pkg::RES_W-1:0]     res_s3,
	output wsrs_pkg::tag_t                        tag_s3
);

	logic signed [wsrs_pkg::R24_W-1:0]   r24_d;
	logic signed [wsrs_pkg::R24_W-1:0]   r24_s2;
	wsrs_pkg::tag_t                      tag_s2;
	logic signed [wsrs_pkg::R24_W-1:0]   rnd;
	logic signed [wsrs_pkg::RFULL_W-1:0] rfull;
	logic signed [wsrs_pkg::RES_W-1:0]   res_d;
	logic                                sat_d;
	wsrs_pkg::tag_t                      tag_d;

	// Combine the lane products and subtract them from the aligned outcome.
	always_comb begin
		r24_d = wsrs_pkg::R24_W'(outcome_s1) <<< wsrs_pkg::FRAC_DROP;
		for (int j = 0; j < NUM_COLS; j++) begin
			r24_d = r24_d - wsrs_pkg::R24_W'(prod_s1[j]);
		end
	end

	// Round to Q.12 with ties upward, then clamp to Q12.12.
	always_comb begin
		rnd   = r24_s2 + wsrs_pkg::RND_HALF;
		rfull = rnd[wsrs_pkg::R24_W-1:wsrs_pkg::FRAC_DROP];
		sat_d = 1'b0;
		res_d = rfull[wsrs_pkg::RES_W-1:0];
		if (rfull > wsrs_pkg::RES_MAX) begin
			res_d = wsrs_pkg::RES_MAX[wsrs_pkg::RES_W-1:0];
			sat_d = 1'b1;
		end else if (rfull < wsrs_pkg::RES_MIN) begin
			res_d = wsrs_pkg::RES_MIN[wsrs_pkg::RES_W-1:0];
			sat_d = 1'b1;
		end
		tag_d     = tag_s2;
		tag_d.sat = tag_s2.sat | sat_d;
	end

	// Payload registers of both stages.
	always_ff @(posedge clk) begin
		if (advance) begin
			r24_s2 <= r24_d;
			res_s3 <= res_d;
		end
	end

	// Sideband registers; only the valid bit needs reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else if (advance) begin
			tag_s2 <= tag_s1;
			tag_s3 <= tag_d;
		end
	end

endmodule

// ----- hdl/wsrs_loss.sv -----
module wsrs_loss (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  advance,
	input  logic signed [wsrs_pkg::RES_W-1:0]     res_s3,
	input  wsrs_pkg::tag_t                        tag_s3,
	output logic                                  out_valid,
	output logic signed [wsrs_pkg::LOSS_W-1:0]    neg_loss,
	output logic                                  saturated
);

	logic signed [2*wsrs_pkg::RES_W-1:0]       sq_full;
	logic [wsrs_pkg::SQ_W-1:0]                 sq_s4;
	wsrs_pkg::tag_t                            tag_s4;
	logic [wsrs_pkg::SQ_W+wsrs_pkg::WGT_W-1:0] wsq_full;
	logic [wsrs_pkg::TERM_W-1:0]               term_s5;
	wsrs_pkg::tag_t                            tag_s5;
	logic [wsrs_pkg::ACC_W-1:0]                acc_q;
	logic                                      sat_q;
	logic [wsrs_pkg::LOSS_W-1:0]               sum;
	logic [wsrs_pkg::ACC_W-1:0]                acc_d;
	logic                                      sat_d;

	// Square of the residual, then the weighted square halved.
	assign sq_full  = res_s3 * res_s3;
	assign wsq_full = sq_s4 * tag_s4.weight;

	always_ff @(posedge clk) begin
		if (advance) begin
			sq_s4   <= sq_full[wsrs_pkg::SQ_W-1:0];
			term_s5 <= wsq_full[wsrs_pkg::SQ_W+wsrs_pkg::WGT_W-1:1];
		end
	end

	// Saturating accumulation; the top bit of the sum flags overflow.
	always_comb begin
		sum   = wsrs_pkg::LOSS_W'(acc_q) + wsrs_pkg::LOSS_W'(term_s5);
		acc_d = sum[wsrs_pkg::ACC_W-1:0];
		sat_d = sat_q | tag_s5.sat;
		if (sum[wsrs_pkg::LOSS_W-1]) begin
			acc_d = '1;
			sat_d = 1'b1;
		end
	end

	// Sideband, accumulator and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s4    <= '0;
			tag_s5    <= '0;
			acc_q     <= '0;
			sat_q     <= 1'b0;
			out_valid <= 1'b0;
			neg_loss  <= '0;
			saturated <= 1'b0;
		end else if (advance) begin
			tag_s4    <= tag_s3;
			tag_s5    <= tag_s4;
			out_valid <= tag_s5.valid & tag_s5.last;
			if (tag_s5.valid) begin
				if (tag_s5.last) begin
					neg_loss  <= '0 - wsrs_pkg::LOSS_W'(acc_d);
					saturated <= sat_d;
					acc_q     <= '0;
					sat_q     <= 1'b0;
				end else begin
					acc_q <= acc_d;
					sat_q <= sat_d;
				end
			end
		end
	end

endmodule
